/* design/dq_pkg.sv */
// Shared types and constants for the double-ended queue.
// No dependencies; imported by dq_cell, dq_chain, the top and its testbench.
package dq_pkg;

  localparam int DATA_W  = 32;
  localparam int OCC_W   = 5;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_STATUS     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_POP_EMPTY  = 2'd2
  } status_t;

  typedef struct packed {
    logic shift_low;
    logic shift_high;
    logic load_tail;
  } cell_op_t;

endpackage

/* design/double_ended_queue_top.sv */
// Double-ended queue top level: control, occupancy count and two cell chains.
// Depends on dq_pkg and dq_chain.
//
// Usage:
//   Requests enter on start/action/push_value and are taken whenever start is
//   high and busy is low; busy is high only while rst is held, so one request
//   per cycle is taken out of reset.
//   Each request returns one result on the cycle after it is taken, marked by
//   done for exactly one cycle: popped_value, front_value, back_value,
//   occupancy, is_empty, is_full and status. Throughput is one request per
//   cycle, set by the shift of the cell chains. The receiver cannot stall; a
//   result not captured is lost.
//   Two chains of DEPTH cells hold the entries, one aligned to the front and
//   one to the back, so both ends sit in cell 0 of a chain.
//   A push into a full queue or a pop from an empty one is refused with a
//   status code and leaves the contents untouched.
//   capacity_limit is written on cfg_valid/cfg_ready/cfg_data; values above
//   DEPTH count as DEPTH. Write it only while no result is outstanding.
//   Reset empties the queue and sets the limit to 16; stored data is not
//   cleared and is never shown before it is written.
module double_ended_queue_top #(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [2:0]                 action,
  input  logic [dq_pkg::DATA_W-1:0]  push_value,
  output logic                       busy,
  output logic                       done,
  output logic [dq_pkg::DATA_W-1:0]  popped_value,
  output logic [dq_pkg::DATA_W-1:0]  front_value,
  output logic [dq_pkg::DATA_W-1:0]  back_value,
  output logic [dq_pkg::OCC_W-1:0]   occupancy,
  output logic                       is_empty,
  output logic                       is_full,
  output logic [1:0]                 status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dq_pkg::LIMIT_W-1:0] cfg_data
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int XW = (ENTRY_WIDTH > DATA_W) ? ENTRY_WIDTH : DATA_W;
  localparam int OW = (CW > OCC_W) ? CW : OCC_W;

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [LIMIT_W-1:0]     capacity_limit;
  logic [ENTRY_WIDTH-1:0] popped;
  logic [ENTRY_WIDTH-1:0] popped_next;
  status_t                status_q;
  status_t                status_next;

  logic                   accept;
  logic [LW-1:0]          limit_ext;
  logic [LW-1:0]          depth_ext;
  logic [LW-1:0]          limit_eff;
  logic                   full;
  logic                   empty;
  logic [XW-1:0]          in_x;
  logic [ENTRY_WIDTH-1:0] in_data;
  logic [ENTRY_WIDTH-1:0] a_head;
  logic [ENTRY_WIDTH-1:0] b_head;
  cell_op_t               op_a;
  cell_op_t               op_b;
  logic [XW-1:0]          pop_x;
  logic [XW-1:0]          front_x;
  logic [XW-1:0]          back_x;
  logic [OW-1:0]          occ_x;

  assign accept    = start && !busy;
  assign busy      = rst;
  assign cfg_ready = 1'b1;

  assign limit_ext = LW'(capacity_limit);
  assign depth_ext = LW'(DEPTH);
  assign limit_eff = (limit_ext > depth_ext) ? depth_ext : limit_ext;
  assign full      = (LW'(count) >= limit_eff);
  assign empty     = (count == '0);

  assign in_x    = XW'(push_value);
  assign in_data = in_x[ENTRY_WIDTH-1:0];

  always_comb begin
    op_a        = '0;
    op_b        = '0;
    count_next  = count;
    status_next = ST_DONE;
    popped_next = '0;
    if (accept) begin
      unique case (action)
        ACT_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_PUSH_FULL;
          end else begin
            op_a.shift_low = 1'b1;
            op_b.load_tail = 1'b1;
            count_next     = count + 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            status_next = ST_PUSH_FULL;
          end else begin
            op_a.load_tail = 1'b1;
            op_b.shift_low = 1'b1;
            count_next     = count + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            status_next = ST_POP_EMPTY;
          end else begin
            op_a.shift_high = 1'b1;
            popped_next     = a_head;
            count_next      = count - 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            status_next = ST_POP_EMPTY;
          end else begin
            op_b.shift_high = 1'b1;
            popped_next     = b_head;
            count_next      = count - 1'b1;
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  dq_chain #(
    .DEPTH (DEPTH),
    .W     (ENTRY_WIDTH),
    .CW    (CW)
  ) u_front_chain (
    .clk       (clk),
    .op        (op_a),
    .count     (count),
    .in_data   (in_data),
    .head_data (a_head)
  );

  dq_chain #(
    .DEPTH (DEPTH),
    .W     (ENTRY_WIDTH),
    .CW    (CW)
  ) u_back_chain (
    .clk       (clk),
    .op        (op_b),
    .count     (count),
    .in_data   (in_data),
    .head_data (b_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      capacity_limit <= CAP_RESET;
      done           <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
      if (cfg_valid && cfg_ready) begin
        capacity_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped   <= popped_next;
      status_q <= status_next;
    end
  end

  assign pop_x   = XW'(popped);
  assign front_x = empty ? '0 : XW'(a_head);
  assign back_x  = empty ? '0 : XW'(b_head);
  assign occ_x   = OW'(count);

  assign popped_value = pop_x[DATA_W-1:0];
  assign front_value  = front_x[DATA_W-1:0];
  assign back_value   = back_x[DATA_W-1:0];
  assign occupancy    = occ_x[OCC_W-1:0];
  assign is_empty     = empty;
  assign is_full      = full;
  assign status       = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= depth_ext)
    else $error("occupancy above built depth");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    done && (status_q != ST_DONE) |-> count == $past(count))
    else $error("refused request changed occupancy");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result strobe without a taken request");

  a_push_refuse: assert property (@(posedge clk) disable iff (rst)
    accept && full && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK)
    |=> done && status_q == ST_PUSH_FULL)
    else $error("push into full queue not refused");
`endif

endmodule

/* design/dq_cell.sv */
// One storage cell of a queue chain: takes its lower or upper neighbour, or the
// request data when it sits at the tail position. Depends on dq_pkg.
module dq_cell #(
  parameter int INDEX = 0,
  parameter int W     = 32,
  parameter int CW    = 5
) (
  input  logic             clk,
  input  dq_pkg::cell_op_t op,
  input  logic [CW-1:0]    count,
  input  logic [W-1:0]     low_data,
  input  logic [W-1:0]     high_data,
  input  logic [W-1:0]     load_data,
  output logic [W-1:0]     data_q
);
  import dq_pkg::*;

  logic hit;

  assign hit = (count == CW'(INDEX));

  always_ff @(posedge clk) begin
    if (op.shift_low) begin
      data_q <= low_data;
    end else if (op.shift_high) begin
      data_q <= high_data;
    end else if (op.load_tail && hit) begin
      data_q <= load_data;
    end
  end

endmodule

/* design/dq_chain.sv */
// Row of dq_cell instances, cell 0 at the head end of the chain.
// Depends on dq_pkg and dq_cell.
module dq_chain #(
  parameter int DEPTH = 16,
  parameter int W     = 32,
  parameter int CW    = 5
) (
  input  logic             clk,
  input  dq_pkg::cell_op_t op,
  input  logic [CW-1:0]    count,
  input  logic [W-1:0]     in_data,
  output logic [W-1:0]     head_data
);
  import dq_pkg::*;

  logic [W-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] low_d;
    logic [W-1:0] high_d;

    if (i == 0) begin : g_first
      assign low_d = in_data;
    end else begin : g_mid_low
      assign low_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign high_d = '0;
    end else begin : g_mid_high
      assign high_d = cell_q[i+1];
    end

    dq_cell #(
      .INDEX (i),
      .W     (W),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (count),
      .low_data  (low_d),
      .high_data (high_d),
      .load_data (in_data),
      .data_q    (cell_q[i])
    );
  end

  assign head_data = cell_q[0];

endmodule

/* verif/tb_double_ended_queue_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_top: directed and random requests,
// each result checked against a scoreboard that tracks the deque contents.
// Depends on dq_pkg and the design sources under design/.
module tb_double_ended_queue_top;
  import dq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 150;
  localparam int SEGMENT_ITEMS = 20;
  localparam logic [2:0] ACT_CODE_MAX = 3'd7;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [DATA_W-1:0] popped;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] back;
    logic [OCC_W-1:0]  occ;
    logic              empty;
    logic              full;
    logic [1:0]        status;
  } deque_view_t;

  class deque_scoreboard;
    logic [DATA_W-1:0]  slots [DEPTH];
    logic [3:0]         head;
    logic [OCC_W-1:0]   count;
    logic [LIMIT_W-1:0] cap;
    deque_view_t        due_views [$];
    int                 mismatches;

    function new();
      head = '0;
      count = '0;
      cap = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_limit(input logic [LIMIT_W-1:0] value);
      cap = value;
    endfunction

    function int pending();
      return due_views.size();
    endfunction

    task report(input string msg);
      if (mismatches < 40) $display("mismatch at %0t ns: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_request(input logic [2:0] act, input logic [DATA_W-1:0] value);
      deque_view_t v;
      logic [OCC_W-1:0] lim;
      v = '0;
      lim = (cap > DEPTH) ? OCC_W'(DEPTH) : cap;
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (count >= lim) begin
            v.status = ST_PUSH_FULL;
          end else if (act == ACT_PUSH_FRONT) begin
            head = head - 4'd1;
            slots[head] = value;
            count = count + 1'b1;
          end else begin
            slots[4'(head + count)] = value;
            count = count + 1'b1;
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (count == 0) begin
            v.status = ST_POP_EMPTY;
          end else if (act == ACT_POP_FRONT) begin
            v.popped = slots[head];
            head = head + 4'd1;
            count = count - 1'b1;
          end else begin
            v.popped = slots[4'(head + count - 1)];
            count = count - 1'b1;
          end
        end
        default: ;
      endcase
      if (count != 0) begin
        v.front = slots[head];
        v.back = slots[4'(head + count - 1)];
      end
      v.occ = count;
      v.empty = (count == 0);
      v.full = (count >= lim);
      due_views.push_back(v);
    endfunction

    task check_result(input deque_view_t got);
      deque_view_t want;
      if (due_views.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = due_views.pop_front();
      if (got.popped !== want.popped)
        report($sformatf("popped_value %h, want %h", got.popped, want.popped));
      if (got.front !== want.front)
        report($sformatf("front_value %h, want %h", got.front, want.front));
      if (got.back !== want.back)
        report($sformatf("back_value %h, want %h", got.back, want.back));
      if (got.occ !== want.occ)
        report($sformatf("occupancy %0d, want %0d", got.occ, want.occ));
      if (got.empty !== want.empty)
        report($sformatf("is_empty %b, want %b", got.empty, want.empty));
      if (got.full !== want.full)
        report($sformatf("is_full %b, want %b", got.full, want.full));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic [2:0]         action;
  logic [DATA_W-1:0]  push_value;
  logic               busy;
  logic               done;
  logic [DATA_W-1:0]  popped_value;
  logic [DATA_W-1:0]  front_value;
  logic [DATA_W-1:0]  back_value;
  logic [OCC_W-1:0]   occupancy;
  logic               is_empty;
  logic               is_full;
  logic [1:0]         status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  deque_scoreboard tracker;
  int limit_plan [12] = '{16, 1, 31, 0, 5, 2, 17, 8, 3, 16, 12, 16};

  double_ended_queue_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (action),
    .push_value   (push_value),
    .busy         (busy),
    .done         (done),
    .popped_value (popped_value),
    .front_value  (front_value),
    .back_value   (back_value),
    .occupancy    (occupancy),
    .is_empty     (is_empty),
    .is_full      (is_full),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && tracker != null) begin
      if (done)
        tracker.check_result({popped_value, front_value, back_value, occupancy,
                              is_empty, is_full, status});
      if (cfg_valid && cfg_ready) tracker.set_limit(cfg_data);
      if (start && !busy) tracker.note_request(action, push_value);
    end
  end

  task automatic send_request(input logic [2:0] act, input logic [DATA_W-1:0] value);
    @(negedge clk);
    start = 1'b1;
    action = act;
    push_value = value;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    start = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_limit(input int value);
    drain_requests();
    cfg_valid = 1'b1;
    cfg_data = LIMIT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int push_bias);
    int roll;
    logic [2:0] act;
    roll = $urandom_range(0, 99);
    if (roll < push_bias)
      act = 3'($urandom_range(ACT_PUSH_FRONT, ACT_PUSH_BACK));
    else if (roll < 94)
      act = 3'($urandom_range(ACT_POP_FRONT, ACT_POP_BACK));
    else
      act = 3'($urandom_range(ACT_STATUS, ACT_CODE_MAX));
    send_request(act, pick_value());
  endtask

  initial begin
    int bias;
    bit idle_on;
    bit last_phase;
    tracker = new();
    rst = 1'b1;
    start = 1'b0;
    action = ACT_STATUS;
    push_value = '0;
    cfg_valid = 1'b0;
    cfg_data = CAP_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(ACT_STATUS, pick_value());
    send_request(ACT_POP_FRONT, ALL_ONES);
    send_request(ACT_POP_BACK, '0);
    send_request(ACT_PUSH_FRONT, ALL_ONES);
    send_request(ACT_PUSH_BACK, '0);
    send_request(ACT_PUSH_FRONT, 32'h8000_0000);
    send_request(ACT_PUSH_BACK, 32'h0000_0001);
    for (int a = ACT_STATUS; a <= ACT_CODE_MAX; a++) send_request(3'(a), $urandom);
    send_request(ACT_POP_BACK, $urandom);
    send_request(ACT_POP_FRONT, $urandom);
    send_request(ACT_POP_FRONT, $urandom);
    send_request(ACT_POP_BACK, $urandom);
    send_request(ACT_POP_FRONT, $urandom);

    write_limit(0);
    send_request(ACT_PUSH_BACK, $urandom);
    send_request(ACT_STATUS, $urandom);
    write_limit(31);
    send_request(ACT_PUSH_FRONT, $urandom);
    write_limit(3);
    send_request(ACT_PUSH_BACK, $urandom);
    send_request(ACT_PUSH_BACK, $urandom);
    send_request(ACT_PUSH_FRONT, $urandom);
    write_limit(1);
    send_request(ACT_STATUS, $urandom);
    send_request(ACT_POP_BACK, $urandom);
    send_request(ACT_PUSH_FRONT, $urandom);
    send_request(ACT_POP_FRONT, $urandom);
    send_request(ACT_POP_BACK, $urandom);

    foreach (limit_plan[p]) begin
      last_phase = (p == $size(limit_plan) - 1);
      write_limit(limit_plan[p]);
      for (int seg = 0; seg < PHASE_ITEMS / SEGMENT_ITEMS + 1; seg++) begin
        case ($urandom_range(0, 2))
          0: bias = 80;
          1: bias = 20;
          default: bias = 50;
        endcase
        idle_on = !last_phase && ($urandom_range(0, 2) != 0);
        for (int i = 0; i < SEGMENT_ITEMS; i++) begin
          send_random(bias);
          if (idle_on && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 4));
        end
      end
    end

    drain_requests();
    repeat (4) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
